### design/indexed_list_insert_delete_top_macros.svh
// assertion helpers for the indexed list block
// both expect clk_i and rst_ni in scope
`ifndef INDEXED_LIST_INSERT_DELETE_TOP_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_TOP_MACROS_SVH

// same-cycle implication
`define ILID_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: lbl failed");

// next-cycle implication
`define ILID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: lbl failed");

`endif

### design/ilid_pkg.sv
package ilid_pkg;

  // list geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int POS_W    = 16;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  localparam logic signed [DATA_W-1:0] RD_BAD = -32'sd1;

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_HEAD   = 3'd1,
    OP_TAIL   = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // command broadcast to every cell
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic                     rd;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

### design/indexed_list_insert_delete_top.sv
// a result is registered and valid in the cycle after its input transaction is accepted
// throughput: one operation per cycle while the input is not stalled; every cell shifts or reads in parallel
// input is stalled only while a finished result waits on a stalled output
// reset clears the element count and the output valid; the cell contents are left
// undefined and only entries below the length are ever read
module indexed_list_insert_delete_top import ilid_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [OP_W-1:0]            op_i,
  input  logic signed [POS_W-1:0]    position_i,
  input  logic signed [DATA_W-1:0]   item_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [DATA_W-1:0]   read_value_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [LEN_W-1:0]           length_o
);

  logic                     in_fire;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] read_value_q, read_value_d;
  status_e                  status_q, status_d;
  logic [LEN_W-1:0]         length_q;

  logic                     pos_neg, pos_lt, pos_gt, full;
  logic [POS_W-1:0]         pos_mag, cnt_ext;
  logic                     ins, del, rd;
  logic [IDX_W-1:0]         idx;
  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] rd_bus;

  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic signed [DATA_W-1:0] cell_rd  [CAPACITY];

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // index checks against the current length
  assign pos_neg = position_i[POS_W-1];
  assign pos_mag = {1'b0, position_i[POS_W-2:0]};
  assign cnt_ext = POS_W'(count_q);
  assign pos_lt  = !pos_neg && (pos_mag < cnt_ext);
  assign pos_gt  = !pos_neg && (pos_mag > cnt_ext);
  assign full    = (count_q == CNT_W'(CAPACITY));

  // operation decode
  always_comb begin
    ins          = 1'b0;
    del          = 1'b0;
    rd           = 1'b0;
    idx          = '0;
    status_d     = ST_DONE;
    unique case (op_i)
      OP_GET: begin
        if (pos_lt) begin
          rd  = 1'b1;
          idx = position_i[IDX_W-1:0];
        end else begin
          status_d = ST_RANGE;
        end
      end
      OP_HEAD: begin
        if (full) status_d = ST_FULL;
        else ins = 1'b1;
      end
      OP_TAIL: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ins = 1'b1;
          idx = IDX_W'(count_q);
        end
      end
      OP_INSERT: begin
        if (pos_gt) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ins = 1'b1;
          idx = pos_neg ? '0 : position_i[IDX_W-1:0];
        end
      end
      OP_DELETE: begin
        if (pos_lt) begin
          del = 1'b1;
          idx = position_i[IDX_W-1:0];
        end else begin
          status_d = ST_RANGE;
        end
      end
      default: status_d = ST_RANGE;
    endcase
  end

  // command to the cell row, writes only on an accepted transaction
  always_comb begin
    ctrl.ins   = ins && in_fire;
    ctrl.del   = del && in_fire;
    ctrl.rd    = rd;
    ctrl.idx   = idx;
    ctrl.value = item_value_i;
  end

  // row of storage cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_val, right_val;
    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end
    ilid_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .ctrl_i     (ctrl),
      .left_i     (left_val),
      .right_i    (right_val),
      .value_o    (cell_val[g]),
      .rd_o       (cell_rd[g])
    );
  end

  // wired-or read bus
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // result and length update
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) count_d = count_q + CNT_W'(1);
    else if (ctrl.del) count_d = count_q - CNT_W'(1);
    if (op_i == OP_GET) begin
      read_value_d = rd ? rd_bus : RD_BAD;
    end else begin
      read_value_d = '0;
    end
    out_valid_d = in_fire || in_stall_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register, loaded on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      read_value_q <= read_value_d;
      status_q     <= status_d;
      length_q     <= LEN_W'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign length_o     = length_q;

endmodule

### design/ilid_cell.sv
module ilid_cell import ilid_pkg::*; (
  input  logic                     clk_i,
  input  logic [IDX_W-1:0]         cell_idx_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] left_i,
  input  logic signed [DATA_W-1:0] right_i,
  output logic signed [DATA_W-1:0] value_o,
  output logic signed [DATA_W-1:0] rd_o
);

  logic signed [DATA_W-1:0] value_q, value_d;

  // shift toward the tail on insert, toward the head on delete
  always_comb begin
    value_d = value_q;
    priority if (ctrl_i.ins && (cell_idx_i > ctrl_i.idx)) begin
      value_d = left_i;
    end else if (ctrl_i.ins && (cell_idx_i == ctrl_i.idx)) begin
      value_d = ctrl_i.value;
    end else if (ctrl_i.del && (cell_idx_i >= ctrl_i.idx)) begin
      value_d = right_i;
    end else begin
      // hold
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // drive the read bus only when addressed
  assign rd_o    = (ctrl_i.rd && (cell_idx_i == ctrl_i.idx)) ? value_q : '0;
  assign value_o = value_q;

endmodule

### design/ilid_checker.sv
`include "indexed_list_insert_delete_top_macros.svh"

module ilid_checker import ilid_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] read_value_o,
  input logic [STATUS_W-1:0]      status_o,
  input logic [LEN_W-1:0]         length_o
);

  // a stalled result holds
  `ILID_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(read_value_o))

  // an accepted transaction shows its result in the next cycle
  `ILID_ASSERT_NEXT(a_in_to_out, in_valid_i && !in_stall_o, out_valid_o)

  // full is reported only at capacity
  `ILID_ASSERT_NOW(a_full_len, out_valid_o && (status_o == ST_FULL), length_o == LEN_W'(CAPACITY))

  // a failed operation reads zero or the error marker
  `ILID_ASSERT_NOW(a_err_read, out_valid_o && (status_o != ST_DONE), (read_value_o == '0) || (read_value_o == RD_BAD))

endmodule

bind indexed_list_insert_delete_top ilid_checker u_ilid_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_value_o (read_value_o),
  .status_o     (status_o),
  .length_o     (length_o)
);
